// File: design/assert_macros.svh
// Assertion macros for the checker file.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define APC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Implication form: antecedent, then consequent in the next cycle.
`define APC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/apc_pkg.sv
// Package for the arithmetic coprocessor: opcodes, status codes, payload types
// and the sequencer state type. No dependencies.
package apc_pkg;

  localparam logic [7:0] OP_ADD   = 8'h2B;
  localparam logic [7:0] OP_SUB   = 8'h2D;
  localparam logic [7:0] OP_MUL   = 8'h2A;
  localparam logic [7:0] OP_DIV   = 8'h2F;
  localparam logic [7:0] OP_PRIME = 8'h70;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_BADOP    = 2'd2;
  localparam logic [1:0] ST_PRIMEERR = 2'd3;

  localparam logic [31:0] TOP_VALUE = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0]         opcode;
    logic signed [31:0] operand_b;
    logic signed [15:0] operand_c;
  } apc_in_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic [1:0]         status;
  } apc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_NEXT,
    S_TEST,
    S_REM
  } apc_state_t;

endpackage

// File: design/arith_prime_coprocessor.sv
// Arithmetic coprocessor: add/sub/mul with a registered result; divide and nth-prime
// search on one shared restoring divider (one quotient bit per cycle).
// Divide runs 32 divider steps; a prime search, per candidate, steps through
// S_NEXT and S_TEST plus up to sqrt(n) trial divisions on the divider.
// One command at a time: the next command can be taken in the cycle after the result transfer.
// Reset (rst_n low, synchronous) returns the sequencer to idle and clears out_valid.
module arith_prime_coprocessor
  import apc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  apc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output apc_out_t out_data
);

  apc_state_t state_r, state_nxt;

  logic        out_valid_r, out_valid_nxt;
  apc_out_t    out_r, out_nxt;
  // divider
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  // prime search
  logic [31:0] cand_r, cand_nxt;
  logic [16:0] trial_r, trial_nxt;
  logic [33:0] sq_r, sq_nxt;
  logic [14:0] found_r, found_nxt;
  logic [14:0] count_r, count_nxt;

  logic        accept;
  logic        out_take;
  logic        div_last;
  logic [32:0] shl;
  logic        ge;
  logic [32:0] rem_step;
  logic [31:0] quo_step;
  logic [31:0] sext_c;
  logic [31:0] mag_b;
  logic [31:0] mag_c;
  logic [31:0] product;
  logic        sq_gt;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Operand preparation
  assign sext_c  = {{16{in_data.operand_c[15]}}, in_data.operand_c};
  assign mag_b   = in_data.operand_b[31] ? (32'd0 - in_data.operand_b) : in_data.operand_b;
  assign mag_c   = sext_c[31] ? (32'd0 - sext_c) : sext_c;
  assign product = in_data.operand_b * sext_c;

  // Shared divider step
  assign shl      = {rem_r, quo_r[31]};
  assign ge       = shl >= {1'b0, dvs_r};
  assign rem_step = ge ? (shl - {1'b0, dvs_r}) : shl;
  assign quo_step = {quo_r[30:0], ge};
  assign div_last = (cnt_r == 5'd31);
  assign sq_gt    = sq_r > {2'b00, cand_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_DIV && sext_c != 32'd0) begin
            state_nxt = S_DIV;
          end else if (in_data.opcode == OP_PRIME && !in_data.operand_c[15]
                       && in_data.operand_c != 16'sd0) begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_DIV: begin
        if (div_last) state_nxt = S_IDLE;
      end
      S_NEXT: begin
        if (cand_r == TOP_VALUE) state_nxt = S_IDLE;
        else state_nxt = S_TEST;
      end
      S_TEST: begin
        if (sq_gt) begin
          if (found_r + 15'd1 == count_r) state_nxt = S_IDLE;
          else state_nxt = S_NEXT;
        end else begin
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        if (div_last) begin
          if (rem_step == 33'd0) state_nxt = S_NEXT;
          else state_nxt = S_TEST;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    cand_nxt      = cand_r;
    trial_nxt     = trial_r;
    sq_nxt        = sq_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    if (out_take) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.answer = 32'sd0;
          out_nxt.status = ST_OK;
          out_valid_nxt  = 1'b1;
          case (in_data.opcode)
            OP_ADD: out_nxt.answer = in_data.operand_b + sext_c;
            OP_SUB: out_nxt.answer = in_data.operand_b - sext_c;
            OP_MUL: out_nxt.answer = product;
            OP_DIV: begin
              if (sext_c == 32'd0) begin
                out_nxt.status = ST_DIVZERO;
              end else begin
                out_valid_nxt = 1'b0;
                rem_nxt = 32'd0;
                quo_nxt = mag_b;
                dvs_nxt = mag_c;
                cnt_nxt = 5'd0;
                neg_nxt = in_data.operand_b[31] ^ sext_c[31];
              end
            end
            OP_PRIME: begin
              if (in_data.operand_c[15]) begin
                out_nxt.status = ST_PRIMEERR;
              end else if (in_data.operand_c == 16'sd0) begin
                out_nxt.answer = in_data.operand_b;
              end else begin
                out_valid_nxt = 1'b0;
                cand_nxt  = (in_data.operand_b < 32'sd1) ? 32'd1 : in_data.operand_b;
                found_nxt = 15'd0;
                count_nxt = in_data.operand_c[14:0];
              end
            end
            default: out_nxt.status = ST_BADOP;
          endcase
        end
      end
      S_DIV: begin
        rem_nxt = rem_step[31:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 5'd1;
        if (div_last) begin
          out_nxt.answer = neg_r ? (32'd0 - quo_step) : quo_step;
          out_nxt.status = ST_OK;
          out_valid_nxt  = 1'b1;
        end
      end
      S_NEXT: begin
        if (cand_r == TOP_VALUE) begin
          out_nxt.answer = 32'sd0;
          out_nxt.status = ST_PRIMEERR;
          out_valid_nxt  = 1'b1;
        end else begin
          cand_nxt  = cand_r + 32'd1;
          trial_nxt = 17'd2;
          sq_nxt    = 34'd4;
        end
      end
      S_TEST: begin
        if (sq_gt) begin
          // no divisor up to sqrt: candidate is prime
          found_nxt = found_r + 15'd1;
          if (found_r + 15'd1 == count_r) begin
            out_nxt.answer = cand_r;
            out_nxt.status = ST_OK;
            out_valid_nxt  = 1'b1;
          end
        end else begin
          rem_nxt = 32'd0;
          quo_nxt = cand_r;
          dvs_nxt = {15'd0, trial_r};
          cnt_nxt = 5'd0;
        end
      end
      S_REM: begin
        rem_nxt = rem_step[31:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 5'd1;
        if (div_last) begin
          // (d+1)^2 = d^2 + 2d + 1
          trial_nxt = trial_r + 17'd1;
          sq_nxt    = sq_r + {16'd0, trial_r, 1'b1};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    cand_r  <= cand_nxt;
    trial_r <= trial_nxt;
    sq_r    <= sq_nxt;
    found_r <= found_nxt;
    count_r <= count_nxt;
  end

endmodule

// File: design/apc_checker.sv
// Port-level checker for the arithmetic coprocessor, bound to the top level.
// Depends on apc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apc_checker
  import apc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input apc_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input apc_out_t out_data
);

  // A held result stays put.
  `APC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // Error status always comes with a zero answer.
  `APC_ASSERT(a_err_zero, out_valid && out_data.status != ST_OK |-> out_data.answer == 32'sd0)
  // One command at a time: busy after each input transfer.
  `APC_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)
  // No input transfer while a result is pending.
  `APC_ASSERT(a_pending, out_valid |-> in_stall)

endmodule

bind arith_prime_coprocessor apc_checker u_apc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/arith_prime_coprocessor_tb.sv
// Testbench for arith_prime_coprocessor: directed and random commands, with an
// internal predictor and an in-order scoreboard. Depends on apc_pkg and the RTL.
`timescale 1ns / 1ps

module arith_prime_coprocessor_tb;
  import apc_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int STALL_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  apc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  apc_out_t out_data;

  apc_out_t pending_results[$];
  int       fail_count = 0;
  int       burst_left = 0;
  int       quiet_cycles = 0;
  int       stall_cycle = 0;
  int       stall_mode = 0;

  arith_prime_coprocessor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Trial division; only small candidates reach this in practice
  function automatic bit is_prime(longint n);
    longint d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected answer and status for one command
  function automatic apc_out_t predict_result(apc_in_t cmd);
    apc_out_t   res;
    logic [31:0] b, c, mb, mc, q;
    longint     cand;
    int         found;
    int         count;
    b = cmd.operand_b;
    c = {{16{cmd.operand_c[15]}}, cmd.operand_c};
    res.answer = '0;
    res.status = ST_OK;
    case (cmd.opcode)
      OP_ADD: res.answer = b + c;
      OP_SUB: res.answer = b - c;
      OP_MUL: res.answer = b * c;
      OP_DIV: begin
        if (c == 0) begin
          res.status = ST_DIVZERO;
        end else begin
          mb = b[31] ? -b : b;
          mc = c[31] ? -c : c;
          q = mb / mc;
          res.answer = (b[31] != c[31]) ? -q : q;
        end
      end
      OP_PRIME: begin
        count = cmd.operand_c;
        if (count < 0) begin
          res.status = ST_PRIMEERR;
        end else if (count == 0) begin
          res.answer = b;
        end else begin
          cand = cmd.operand_b;
          if (cand < 1) cand = 1;
          found = 0;
          while (found != count && res.status == ST_OK) begin
            cand++;
            if (cand > longint'(TOP_VALUE)) res.status = ST_PRIMEERR;
            else if (is_prime(cand)) found++;
          end
          if (res.status == ST_OK) res.answer = cand[31:0];
        end
      end
      default: res.status = ST_BADOP;
    endcase
    if (res.status != ST_OK) res.answer = '0;
    return res;
  endfunction

  // Send one command in bursts with random gaps; record expectation on transfer
  task automatic send_cmd(logic [7:0] op, logic [31:0] b, logic [15:0] c);
    apc_in_t cmd;
    int gap;
    cmd.opcode = op;
    cmd.operand_b = b;
    cmd.operand_c = c;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_result(cmd));
    burst_left--;
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      apc_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result answer=%h status=%0d",
                 $time, out_data.answer, out_data.status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.answer !== want.answer) begin
          $display("%0t: answer mismatch expected=%h actual=%h",
                   $time, want.answer, out_data.answer);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d",
                   $time, want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall pattern in one of four randomly redrawn modes
  always @(negedge clk) begin
    stall_cycle++;
    if (stall_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= stall_cycle[2];
      default: out_stall <= (stall_cycle % 32) < 20;
    endcase
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_arith_extremes();
    send_cmd(OP_ADD, 32'h7FFF_FFFF, 16'h0001);
    send_cmd(OP_ADD, 32'h8000_0000, 16'h8000);
    send_cmd(OP_SUB, 32'h8000_0000, 16'h0001);
    send_cmd(OP_SUB, 32'hFFFF_FFFF, 16'h7FFF);
    send_cmd(OP_MUL, 32'h7FFF_FFFF, 16'h7FFF);
    send_cmd(OP_MUL, 32'h8000_0000, 16'hFFFF);
  endtask

  task automatic test_divide();
    send_cmd(OP_DIV, 32'd12345, 16'h0000);
    send_cmd(OP_DIV, 32'h8000_0000, 16'hFFFF);
    send_cmd(OP_DIV, -32'sd7, 16'h0002);
    send_cmd(OP_DIV, 32'd7, 16'hFFFE);
    send_cmd(OP_DIV, 32'h7FFF_FFFF, 16'h8000);
  endtask

  task automatic test_bad_opcodes();
    send_cmd(8'h00, 32'd1, 16'd1);
    send_cmd(8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_cmd(8'h50, 32'd3, 16'd4);
  endtask

  task automatic test_prime_cases();
    send_cmd(OP_PRIME, 32'h7FFF_FFFF, 16'h0000);
    send_cmd(OP_PRIME, 32'h8000_0000, 16'h0000);
    send_cmd(OP_PRIME, 32'd10, 16'h8000);
    send_cmd(OP_PRIME, 32'd10, 16'hFFFF);
    send_cmd(OP_PRIME, 32'h7FFF_FFFF, 16'h0001);
    send_cmd(OP_PRIME, 32'h8000_0000, 16'h0001);
    send_cmd(OP_PRIME, 32'd0, 16'd1);
    send_cmd(OP_PRIME, 32'd1, 16'd3);
    send_cmd(OP_PRIME, 32'd2, 16'd1);
    send_cmd(OP_PRIME, 32'd13, 16'd5);
  endtask

  // Mostly arithmetic with full-range operands; prime searches mostly on small bases
  task automatic test_random(int n_items);
    logic [7:0]  op;
    logic [31:0] b;
    logic [15:0] c;
    int sel;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      b = $urandom;
      c = 16'($urandom);
      if (sel < 20) op = OP_ADD;
      else if (sel < 40) op = OP_SUB;
      else if (sel < 58) op = OP_MUL;
      else if (sel < 78) begin
        op = OP_DIV;
        if ($urandom_range(0, 9) == 0) c = '0;
        else if ($urandom_range(0, 3) == 0) c = 16'($urandom_range(0, 15) - 8);
      end else if (sel < 88) begin
        op = OP_PRIME;
        b = $urandom_range(0, 560) - 60;
        c = ($urandom_range(0, 7) == 0) ? (16'h8000 | 16'($urandom))
                                        : 16'($urandom_range(0, 6));
      end else if (sel < 90) begin
        op = OP_PRIME;
        b = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000 | $urandom;
        c = 16'($urandom_range(0, 1));
      end else begin
        op = 8'($urandom);
      end
      send_cmd(op, b, c);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_arith_extremes();
    test_divide();
    test_bad_opcodes();
    test_prime_cases();
    test_random(1530);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
